// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; ifba_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The antecedent implies the consequent in the cycle after it.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ifba_pkg.sv =====
// ----------------------------------------------------------------------------
// ifba_pkg
// Types and constants of the indexed file block allocator.
// ----------------------------------------------------------------------------
package ifba_pkg;

    localparam int NUM_ENTRIES     = 16;
    localparam int NUM_DISK_BLOCKS = 128;
    localparam int MAX_FILE_BLOCKS = 8;
    localparam int NAME_CHARS      = 7;

    localparam int SLOT_W  = $clog2(NUM_ENTRIES);
    localparam int BLK_W   = $clog2(NUM_DISK_BLOCKS);
    localparam int FBI_W   = $clog2(MAX_FILE_BLOCKS);
    localparam int LIST_W  = SLOT_W + FBI_W;
    localparam int NAME_W  = 56;
    localparam int CNT_W   = 4;
    localparam int FREE_W  = BLK_W + 1;
    localparam int SCNT_W  = (SLOT_W > BLK_W ? SLOT_W : BLK_W) + 1;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_CREATE = 2'd0;
    localparam t_cmd CMD_DELETE = 2'd1;
    localparam t_cmd CMD_READ   = 2'd2;
    localparam t_cmd CMD_WRITE  = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_TOO_MANY  = 3'd1;
    localparam t_status ST_EXISTS    = 3'd2;
    localparam t_status ST_NO_SPACE  = 3'd3;
    localparam t_status ST_NO_ENTRY  = 3'd4;
    localparam t_status ST_NOT_FOUND = 3'd5;
    localparam t_status ST_BAD_BLOCK = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item, clear scan counter
        logic scan_step;  // compare one entry, advance counter
        logic alloc_step; // test one disk block, take it if needed
        logic free_step;  // release one block of the found file
        logic commit;     // write the new entry
        logic drop;       // mark the found entry unused
        logic rd_list;    // start a block-list read at the lookup index
    } t_cmd_bus;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic cnt_bad;    // count above the per-file limit
        logic scan_last;  // scan counter at its last entry
        logic found;      // name match seen
        logic empty_seen; // an unused entry exists
        logic space_ok;   // enough free blocks
        logic alloc_done; // all requested blocks taken
        logic free_done;  // all blocks of the file released
        logic idx_bad;    // lookup index beyond the file
    } t_stat_bus;

    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] v);
        logic [NAME_W-1:0] out;
        logic              live;
        out  = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_CHARS; b++) begin
            if (v[8*b +: 8] == 8'd0) live = 1'b0;
            if (live) out[8*b +: 8] = v[8*b +: 8];
        end
        return out;
    endfunction

endpackage

// ===== rtl/ifba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifba_ctrl
// Sequencer of the allocator: runs scan, allocate, free and lookup phases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  ifba_pkg::t_stat_bus i_stat,
    output ifba_pkg::t_cmd_bus  o_cmd,
    output ifba_pkg::t_status   o_status,
    output logic                o_use_slot,
    output logic                o_use_blk
);
    import ifba_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_ALLOC = 7'b0000100,
        S_FREE  = 7'b0001000,
        S_LOOK  = 7'b0010000,
        S_RD    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_use_slot, n_use_slot;
    logic    r_use_blk, n_use_blk;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_status;
    assign o_use_slot  = r_use_slot;
    assign o_use_blk   = r_use_blk;

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_use_slot = r_use_slot;
        n_use_blk  = r_use_blk;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_use_slot = 1'b0;
                    n_use_blk  = 1'b0;
                    n_state    = S_OUT;
                    if (i_stat.cmd == CMD_CREATE) begin
                        if (i_stat.cnt_bad) n_status = ST_TOO_MANY;
                        else if (i_stat.found) n_status = ST_EXISTS;
                        else if (!i_stat.space_ok) n_status = ST_NO_SPACE;
                        else if (!i_stat.empty_seen) n_status = ST_NO_ENTRY;
                        else begin
                            n_status   = ST_OK;
                            n_use_slot = 1'b1;
                            n_state    = S_ALLOC;
                        end
                    end else if (!i_stat.found) begin
                        n_status = ST_NOT_FOUND;
                    end else if (i_stat.cmd == CMD_DELETE) begin
                        n_status   = ST_OK;
                        n_use_slot = 1'b1;
                        n_state    = S_FREE;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_ALLOC: begin
                if (i_stat.alloc_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.alloc_step = 1'b1;
                end
            end
            S_FREE: begin
                if (i_stat.free_done) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    o_cmd.free_step = 1'b1;
                end
            end
            S_LOOK: begin
                if (i_stat.idx_bad) begin
                    n_status = ST_BAD_BLOCK;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.rd_list = 1'b1;
                    n_status      = ST_OK;
                    n_use_slot    = 1'b1;
                    n_use_blk     = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_status   <= ST_OK;
            r_use_slot <= 1'b0;
            r_use_blk  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_status   <= n_status;
            r_use_slot <= n_use_slot;
            r_use_blk  <= n_use_blk;
        end
    end

    `ASSERT_ALWAYS(a_blk_ok, i_clk, i_rst_n, !(o_out_valid && o_use_blk) || r_status == ST_OK, "block shown with error")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(r_status), "result dropped")
    `ASSERT_ALWAYS(a_one_step, i_clk, i_rst_n, $countones({o_cmd.alloc_step, o_cmd.free_step, o_cmd.scan_step}) <= 1, "two phases at once")

endmodule

// ===== rtl/ifba_dp.sv =====
// ----------------------------------------------------------------------------
// ifba_dp
// Datapath: directory, free map, block list memory and their counters.
// ----------------------------------------------------------------------------
module ifba_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ifba_pkg::t_cmd                i_command,
    input  logic [ifba_pkg::NAME_W-1:0]   i_file_name,
    input  logic [ifba_pkg::CNT_W-1:0]    i_block_count,
    input  logic [2:0]                    i_block_index,
    input  ifba_pkg::t_cmd_bus            i_cmd,
    output ifba_pkg::t_stat_bus           o_stat,
    output logic [ifba_pkg::SLOT_W-1:0]   o_slot,
    output logic [ifba_pkg::BLK_W-1:0]    o_blk
);
    import ifba_pkg::*;

    logic [NUM_DISK_BLOCKS-1:0] r_free;
    logic [FREE_W-1:0]          r_nfree;
    logic [NUM_ENTRIES-1:0]     r_inuse;
    logic [NAME_W-1:0]          r_names [NUM_ENTRIES];
    logic [CNT_W-1:0]           r_counts [NUM_ENTRIES];
    logic [BLK_W-1:0]           r_list [NUM_ENTRIES*MAX_FILE_BLOCKS];

    t_cmd              r_cmd;
    logic [NAME_W-1:0] r_name;
    logic [CNT_W-1:0]  r_cnt;
    logic [2:0]        r_idx;
    logic [SCNT_W-1:0] r_ptr;
    logic [FBI_W:0]    r_k;
    logic              r_found, r_empty;
    logic [SLOT_W-1:0] r_fslot, r_eslot;
    logic [CNT_W-1:0]  r_fcnt;
    logic [BLK_W-1:0]  r_rd;
    logic [BLK_W-1:0]  r_fblk;
    logic              r_fblk_ok;

    logic [SLOT_W-1:0] w_sidx;
    logic [BLK_W-1:0]  w_bidx;
    logic [LIST_W-1:0] w_eaddr, w_faddr, w_laddr;
    logic              w_take;
    logic              w_fmore;

    assign w_sidx  = r_ptr[SLOT_W-1:0];
    assign w_bidx  = r_ptr[BLK_W-1:0];
    assign w_eaddr = {r_eslot, r_k[FBI_W-1:0]};
    assign w_faddr = {r_fslot, r_k[FBI_W-1:0]};
    assign w_laddr = {r_fslot, r_idx[FBI_W-1:0]};
    assign w_take  = i_cmd.alloc_step && r_free[w_bidx];
    // Blocks of the found file remain to be read from the list.
    assign w_fmore = ((FBI_W+1 > CNT_W ? FBI_W+1 : CNT_W)'(r_k) <
                      (FBI_W+1 > CNT_W ? FBI_W+1 : CNT_W)'(r_fcnt));

    assign o_stat.cmd        = r_cmd;
    assign o_stat.cnt_bad    = ({1'b0, r_cnt} > (CNT_W+1)'(MAX_FILE_BLOCKS));
    assign o_stat.scan_last  = (r_ptr == SCNT_W'(NUM_ENTRIES-1));
    assign o_stat.found      = r_found ||
                               (r_inuse[w_sidx] && r_names[w_sidx] == r_name);
    assign o_stat.empty_seen = r_empty || !r_inuse[w_sidx];
    assign o_stat.space_ok   = (r_nfree >= FREE_W'(r_cnt));
    assign o_stat.alloc_done = ((FBI_W+1 > CNT_W ? FBI_W+1 : CNT_W)'(r_k) >=
                                (FBI_W+1 > CNT_W ? FBI_W+1 : CNT_W)'(r_cnt));
    assign o_stat.free_done  = !w_fmore && !r_fblk_ok;
    assign o_stat.idx_bad    = ({1'b0, r_idx} >= (CNT_W+1)'(r_fcnt)) ||
                               (32'(r_idx) >= MAX_FILE_BLOCKS);

    assign o_slot = r_found ? r_fslot : r_eslot;
    assign o_blk  = r_rd;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= {{(NUM_DISK_BLOCKS-1){1'b1}}, 1'b0};
            r_nfree   <= FREE_W'(NUM_DISK_BLOCKS-1);
            r_inuse   <= '0;
            r_ptr     <= '0;
            r_k       <= '0;
            r_found   <= 1'b0;
            r_empty   <= 1'b0;
            r_fblk_ok <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ptr   <= '0;
                r_k     <= '0;
                r_found <= 1'b0;
                r_empty <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (!r_found && r_inuse[w_sidx] && r_names[w_sidx] == r_name)
                    r_found <= 1'b1;
                if (!r_empty && !r_inuse[w_sidx]) r_empty <= 1'b1;
                // After the scan the pointer walks disk blocks from block 1.
                r_ptr <= o_stat.scan_last ? SCNT_W'(1) : r_ptr + 1'b1;
            end
            if (i_cmd.alloc_step) begin
                r_ptr <= r_ptr + 1'b1;
                if (w_take) begin
                    r_free[w_bidx] <= 1'b0;
                    r_nfree        <= r_nfree - 1'b1;
                    r_k            <= r_k + 1'b1;
                end
            end
            // Freeing is a two-step pipeline: read the list, then set the free bit.
            r_fblk_ok <= i_cmd.free_step && w_fmore;
            if (i_cmd.free_step && w_fmore) r_k <= r_k + 1'b1;
            if (r_fblk_ok) begin
                r_free[r_fblk] <= 1'b1;
                r_nfree        <= r_nfree + 1'b1;
            end
            if (i_cmd.commit) r_inuse[r_eslot] <= 1'b1;
            if (i_cmd.drop)   r_inuse[r_fslot] <= 1'b0;
        end
    end

    // Payload registers and stores.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_name <= canon_name(i_file_name);
            r_cnt  <= i_block_count;
            r_idx  <= i_block_index;
        end
        if (i_cmd.scan_step) begin
            if (!r_found && r_inuse[w_sidx] && r_names[w_sidx] == r_name) begin
                r_fslot <= w_sidx;
                r_fcnt  <= r_counts[w_sidx];
            end
            if (!r_empty && !r_inuse[w_sidx]) r_eslot <= w_sidx;
        end
        if (w_take) r_list[w_eaddr] <= w_bidx;
        if (i_cmd.commit) begin
            r_names[r_eslot]  <= r_name;
            r_counts[r_eslot] <= r_cnt;
        end
        if (i_cmd.free_step) r_fblk <= r_list[w_faddr];
        if (i_cmd.rd_list)   r_rd   <= r_list[w_laddr];
        if (i_cmd.drop)      r_counts[r_fslot] <= '0;
    end

endmodule

// ===== rtl/indexed_file_block_allocator.sv =====
// ----------------------------------------------------------------------------
// indexed_file_block_allocator
// File directory with a free-block bitmap and per-file block lists.
// ----------------------------------------------------------------------------
// One input channel carries a command (create, delete, read or write lookup)
// with a name, a block count and a file block index. One output channel
// returns a status, the entry slot and the physical block for every command.
// Only one command is in flight at a time: input stall is high from the
// accepting edge until the result transfer completes.
// Every command first walks the 16 directory entries, one a cycle. A create
// that passes its checks then walks the disk bitmap from block 1 up to the
// last block taken, one block a cycle, and then writes the entry. A delete
// of a found file reads each of its blocks from the list and frees it, then
// marks the entry unused. A lookup checks the block index and then reads the
// list memory. The next command is accepted in the cycle after the result
// transfer at the earliest.
// Reset empties the directory and frees every disk block but block 0; it is
// done at once, without a clearing pass. While the receiver stalls, the result
// holds and no new command is accepted.
module indexed_file_block_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_command,
    input  logic [ifba_pkg::NAME_W-1:0] i_file_name,
    input  logic [3:0]                  i_block_count,
    input  logic [2:0]                  i_block_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_status,
    output logic [3:0]                  o_file_slot,
    output logic [6:0]                  o_physical_block
);
    import ifba_pkg::*;

    t_cmd_bus          w_cmd;
    t_stat_bus         w_stat;
    t_status           w_status;
    logic              w_use_slot, w_use_blk;
    logic [SLOT_W-1:0] w_slot;
    logic [BLK_W-1:0]  w_blk;

    ifba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_status    (w_status),
        .o_use_slot  (w_use_slot),
        .o_use_blk   (w_use_blk)
    );

    ifba_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_command),
        .i_file_name   (i_file_name),
        .i_block_count (i_block_count),
        .i_block_index (i_block_index),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_slot        (w_slot),
        .o_blk         (w_blk)
    );

    assign o_status         = w_status;
    assign o_file_slot      = w_use_slot ? 4'(w_slot) : 4'd0;
    assign o_physical_block = w_use_blk ? 7'(w_blk) : 7'd0;

endmodule

// ===== tb/sv/ifba_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ifba_checker
// Watches both channels of the file block allocator, predicts each result
// from its own copy of the directory and free map, and counts mismatches.
// ----------------------------------------------------------------------------
module ifba_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [1:0]                  i_command,
    input  logic [ifba_pkg::NAME_W-1:0] i_file_name,
    input  logic [3:0]                  i_block_count,
    input  logic [2:0]                  i_block_index,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [2:0]                  i_status,
    input  logic [3:0]                  i_file_slot,
    input  logic [6:0]                  i_physical_block,
    output int                          o_errors,
    output int                          o_pending
);
    import ifba_pkg::*;

    typedef struct packed {
        t_status    status;
        logic [3:0] slot;
        logic [6:0] pblk;
    } t_answer;

    bit                dsk_free [NUM_DISK_BLOCKS];
    bit                dir_used [NUM_ENTRIES];
    logic [NAME_W-1:0] dir_name [NUM_ENTRIES];
    int                dir_cnt  [NUM_ENTRIES];
    logic [6:0]        dir_blks [NUM_ENTRIES][MAX_FILE_BLOCKS];
    t_answer           answer_q[$];

    // A name ends at its first zero byte.
    function automatic logic [NAME_W-1:0] trim_name(logic [NAME_W-1:0] v);
        logic [NAME_W-1:0] r;
        r = '0;
        for (int b = 0; b < NAME_CHARS; b++) begin
            if (v[8*b +: 8] == 8'd0) break;
            r[8*b +: 8] = v[8*b +: 8];
        end
        return r;
    endfunction

    function automatic t_answer apply_command(t_cmd cmd, logic [NAME_W-1:0] raw,
                                              int cnt, int idx);
        logic [NAME_W-1:0] nm;
        int hit, nfree, slot, k;
        t_answer a;
        nm  = trim_name(raw);
        a   = '{ST_OK, 4'd0, 7'd0};
        hit = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (hit < 0 && dir_used[i] && dir_name[i] == nm) hit = i;
        if (cmd == CMD_CREATE) begin
            nfree = 0;
            slot  = -1;
            for (int i = 1; i < NUM_DISK_BLOCKS; i++) nfree += dsk_free[i];
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (slot < 0 && !dir_used[i]) slot = i;
            if (cnt > MAX_FILE_BLOCKS) a.status = ST_TOO_MANY;
            else if (hit >= 0) a.status = ST_EXISTS;
            else if (nfree < cnt) a.status = ST_NO_SPACE;
            else if (slot < 0) a.status = ST_NO_ENTRY;
            else begin
                dir_used[slot] = 1;
                dir_name[slot] = nm;
                dir_cnt[slot]  = cnt;
                k = 0;
                for (int i = 1; i < NUM_DISK_BLOCKS && k < cnt; i++)
                    if (dsk_free[i]) begin
                        dir_blks[slot][k] = 7'(i);
                        dsk_free[i] = 0;
                        k++;
                    end
                a.slot = 4'(slot);
            end
        end else if (hit < 0) begin
            a.status = ST_NOT_FOUND;
        end else if (cmd == CMD_DELETE) begin
            dir_used[hit] = 0;
            for (int j = 0; j < dir_cnt[hit]; j++) dsk_free[dir_blks[hit][j]] = 1;
            dir_cnt[hit] = 0;
            a.slot = 4'(hit);
        end else if (idx >= dir_cnt[hit]) begin
            a.status = ST_BAD_BLOCK;
        end else begin
            a.slot = 4'(hit);
            a.pblk = dir_blks[hit][idx];
        end
        return a;
    endfunction

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        t_answer exp_a, got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DISK_BLOCKS; i++) dsk_free[i] = (i != 0);
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                dir_used[i] = 0;
                dir_cnt[i]  = 0;
            end
            answer_q.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_file_slot, i_physical_block};
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_a = answer_q.pop_front();
                    if (got !== exp_a) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_a, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                answer_q.push_back(apply_command(i_command, i_file_name,
                                                 i_block_count, i_block_index));
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the indexed file block allocator.
// ----------------------------------------------------------------------------
// Directed commands cover the limits and error codes, then random traffic
// drawn from a small name pool builds and tears down files. A checker module
// predicts and compares every result transfer.
module tb;
    import ifba_pkg::*;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [1:0]        command = CMD_CREATE;
    logic [NAME_W-1:0] file_name = '0;
    logic [3:0]        block_count = '0;
    logic [2:0]        block_index = '0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [2:0]        status;
    logic [3:0]        file_slot;
    logic [6:0]        physical_block;
    int                errors, pending;
    int                snd_idle = 0, rcv_idle = 0;
    bit                hold_off = 0;
    logic [NAME_W-1:0] name_pool [12];

    always #5 clk = ~clk;

    indexed_file_block_allocator u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_command(command), .i_file_name(file_name), .i_block_count(block_count),
        .i_block_index(block_index), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_file_slot(file_slot), .o_physical_block(physical_block)
    );

    ifba_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_command(command), .i_file_name(file_name), .i_block_count(block_count),
        .i_block_index(block_index), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_status(status), .i_file_slot(file_slot), .i_physical_block(physical_block),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < rcv_idle);
    end

    // One transfer; valid stays high through back-to-back items.
    task automatic send(t_cmd c, logic [NAME_W-1:0] nm, logic [3:0] cnt,
                        logic [2:0] idx);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= c;
        file_name   <= nm;
        block_count <= cnt;
        block_index <= idx;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic random_command();
        logic [NAME_W-1:0] nm;
        int r;
        r  = $urandom_range(99);
        nm = name_pool[$urandom_range(11)];
        // Junk above the terminating zero byte must be ignored.
        if ($urandom_range(9) == 0) nm = NAME_W'({$urandom, $urandom});
        if (r < 40)
            send(CMD_CREATE, nm, 4'(($urandom_range(19) == 0) ? $urandom_range(15)
                                                               : $urandom_range(8)),
                 3'd0);
        else if (r < 60) send(CMD_DELETE, nm, 4'($urandom), 3'($urandom));
        else send(r < 80 ? CMD_READ : CMD_WRITE, nm, 4'($urandom), 3'($urandom));
    endtask

    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        for (int i = 0; i < 12; i++)
            name_pool[i] = {32'hA5A5_0000 | $urandom, 24'd0} | (56'h41 + i);
        name_pool[0] = '0;
        name_pool[1] = {8'hFF, 48'h00_4847_4645_44};
        name_pool[2] = 56'h47_4645_4443_4241;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle = 37;
        rcv_idle = 80;
        send(CMD_CREATE, '0, 4'd15, 3'd0);
        send(CMD_CREATE, '0, 4'd9, 3'd0);
        send(CMD_CREATE, '0, 4'd0, 3'd0);
        send(CMD_CREATE, 56'h00_4100, 4'd1, 3'd0);
        send(CMD_READ, '0, 4'd0, 3'd0);
        send(CMD_CREATE, name_pool[2], 4'd8, 3'd0);
        send(CMD_CREATE, name_pool[2], 4'd1, 3'd0);
        send(CMD_WRITE, name_pool[2], 4'd0, 3'd7);
        send(CMD_READ, name_pool[2], 4'd0, 3'd0);
        send(CMD_CREATE, name_pool[1], 4'd8, 3'd0);
        send(CMD_WRITE, 56'h00_0000_0000_0044 | name_pool[1], 4'd0, 3'd3);
        send(CMD_READ, 56'h99, 4'd0, 3'd0);
        send(CMD_DELETE, 56'h99, 4'd0, 3'd0);
        send(CMD_DELETE, name_pool[2], 4'd0, 3'd0);
        send(CMD_READ, name_pool[2], 4'd0, 3'd0);
        // Fill the disk until space runs out, then the directory.
        for (int i = 0; i < 18; i++)
            send(CMD_CREATE, 56'h1000 + i + 1, 4'd8, 3'd0);
        send(CMD_WRITE, 56'h1010, 4'd0, 3'd7);
        for (int i = 0; i < 18; i++)
            send(CMD_DELETE, 56'h1000 + i + 1, 4'd0, 3'd0);
        for (int i = 0; i < 17; i++)
            send(CMD_CREATE, 56'h2000 + i + 1, 4'd0, 3'd0);
        for (int i = 0; i < 17; i++)
            send(CMD_DELETE, 56'h2000 + i + 1, 4'd0, 3'd0);

        // Long receiver hold-off while the sender keeps offering.
        hold_off = 1;
        fork
            begin repeat (400) @(posedge clk); hold_off = 0; end
            repeat (4) random_command();
        join

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = (ph == 0) ? 37 : (ph == 1) ? 80 : 0;
            rcv_idle = (ph == 0) ? 80 : (ph == 1) ? 37 : 0;
            repeat (450) random_command();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end

endmodule
